### rtl/cstk_pkg.sv
// Shared types and codes for the cosine-similarity top-K search block.
`timescale 1ns / 1ps
`default_nettype none

package cstk_pkg;

  typedef enum logic [1:0] {
    MODE_DOC    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY,
    ST_REMOVE,
    ST_NOTFOUND,
    ST_SC_RD,
    ST_SC_CHK,
    ST_EL_RD,
    ST_EL_GO,
    ST_EL_WAIT,
    ST_EMIT
  } top_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XY,
    S_XX,
    S_YY,
    S_ACC,
    S_NZ,
    S_LP,
    S_LD,
    S_S0,
    S_S1,
    S_S2,
    S_FIN,
    S_DONE
  } su_state_t;

  typedef struct packed {
    logic el_valid;
    logic el_first;
    logic el_last;
  } score_ctl_t;

  typedef struct packed {
    logic               ready;
    logic               done;
    logic signed [15:0] score;
  } score_sts_t;

endpackage

`default_nettype wire

### rtl/cstk_score.sv
// Cosine score unit: one shared 32x32 multiplier, accumulators and a bitwise root search.
`timescale 1ns / 1ps
`default_nettype none

module cstk_score
  import cstk_pkg::*;
#(
  parameter int NORM_W = 40
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire score_ctl_t         ctl,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  output score_sts_t              sts
);

  localparam int DOT_W = NORM_W + 1;
  localparam int PW    = 2 * NORM_W;
  localparam int SW    = PW + 32;

  su_state_t state_r, state_nxt;
  logic signed [15:0] x_r, x_nxt, y_r, y_nxt;
  logic last_r, last_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [6:0] sh_r, sh_nxt;
  logic pneg_r, pneg_nxt;
  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [NORM_W-1:0] na_r, na_nxt, nb_r, nb_nxt, ad_r, ad_nxt;
  logic dneg_r, dneg_nxt;
  logic [PW-1:0] p_r, p_nxt, d_r, d_nxt;
  logic [2:0] lm_r, lm_nxt;
  logic [SW-1:0] t_r, t_nxt, u_r, u_nxt, c_r, c_nxt;
  logic [15:0] m_r, m_nxt;
  logic [3:0] b_r, b_nxt;
  logic signed [15:0] score_r, score_nxt;

  logic [31:0] mul_a, mul_b;
  logic [NORM_W-1:0] src_a, src_b;
  logic [31:0] limb_a, limb_b;
  logic [6:0] limb_sh;
  logic [15:0] mag_x, mag_y;
  logic [PW-1:0] prod_sh;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  assign mag_x = mag16(x_r);
  assign mag_y = mag16(y_r);
  assign src_a = (state_r == S_LD) ? ad_r : na_r;
  assign src_b = (state_r == S_LD) ? ad_r : nb_r;
  assign prod_sh = PW'(prod_r) << sh_r;

  // limb order: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    limb_a  = src_a[31:0];
    limb_b  = src_b[31:0];
    limb_sh = 7'd0;
    case (lm_r[1:0])
      2'd1: begin
        limb_b  = 32'(src_b[NORM_W-1:32]);
        limb_sh = 7'd32;
      end
      2'd2: begin
        limb_a  = 32'(src_a[NORM_W-1:32]);
        limb_sh = 7'd32;
      end
      2'd3: begin
        limb_a  = 32'(src_a[NORM_W-1:32]);
        limb_b  = 32'(src_b[NORM_W-1:32]);
        limb_sh = 7'd64;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    last_nxt = last_r;
    prod_nxt = prod_r;
    sh_nxt = sh_r;
    pneg_nxt = pneg_r;
    dot_nxt = dot_r;
    na_nxt = na_r;
    nb_nxt = nb_r;
    ad_nxt = ad_r;
    dneg_nxt = dneg_r;
    p_nxt = p_r;
    d_nxt = d_r;
    lm_nxt = lm_r;
    t_nxt = t_r;
    u_nxt = u_r;
    c_nxt = c_r;
    m_nxt = m_r;
    b_nxt = b_r;
    score_nxt = score_r;
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.el_valid) begin
          x_nxt = x;
          y_nxt = y;
          last_nxt = ctl.el_last;
          if (ctl.el_first) begin
            dot_nxt = '0;
            na_nxt = '0;
            nb_nxt = '0;
          end
          state_nxt = S_XY;
        end
      end
      S_XY: begin
        mul_a = 32'(mag_x);
        mul_b = 32'(mag_y);
        prod_nxt = mul_a * mul_b;
        pneg_nxt = x_r[15] ^ y_r[15];
        state_nxt = S_XX;
      end
      S_XX: begin
        dot_nxt = pneg_r ? dot_r - DOT_W'(prod_r) : dot_r + DOT_W'(prod_r);
        mul_a = 32'(mag_x);
        mul_b = 32'(mag_x);
        prod_nxt = mul_a * mul_b;
        state_nxt = S_YY;
      end
      S_YY: begin
        na_nxt = na_r + NORM_W'(prod_r);
        mul_a = 32'(mag_y);
        mul_b = 32'(mag_y);
        prod_nxt = mul_a * mul_b;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        nb_nxt = nb_r + NORM_W'(prod_r);
        state_nxt = last_r ? S_NZ : S_IDLE;
      end
      S_NZ: begin
        if (na_r == '0 || nb_r == '0) begin
          score_nxt = 16'sd0;
          state_nxt = S_DONE;
        end else begin
          dneg_nxt = dot_r[DOT_W-1];
          ad_nxt = dot_r[DOT_W-1] ? NORM_W'(-dot_r) : NORM_W'(dot_r);
          lm_nxt = 3'd0;
          p_nxt = '0;
          state_nxt = S_LP;
        end
      end
      S_LP, S_LD: begin
        if (lm_r != 3'd0) begin
          if (state_r == S_LP) p_nxt = p_r + prod_sh;
          else d_nxt = d_r + prod_sh;
        end
        if (lm_r != 3'd4) begin
          mul_a = limb_a;
          mul_b = limb_b;
          prod_nxt = mul_a * mul_b;
          sh_nxt = limb_sh;
          lm_nxt = lm_r + 3'd1;
        end else begin
          lm_nxt = 3'd0;
          if (state_r == S_LP) begin
            d_nxt = '0;
            state_nxt = S_LD;
          end else begin
            t_nxt = '0;
            u_nxt = '0;
            m_nxt = '0;
            b_nxt = 4'd15;
            state_nxt = S_S0;
          end
        end
      end
      // trial (m + 2^b)^2 * P = T + U*2^(b+1) + P*2^(2b), U = m*P
      S_S0: begin
        c_nxt = t_r + (u_r << ({1'b0, b_r} + 5'd1));
        state_nxt = S_S1;
      end
      S_S1: begin
        c_nxt = c_r + (SW'(p_r) << {b_r, 1'b0});
        state_nxt = S_S2;
      end
      S_S2: begin
        if (c_r <= (SW'(d_r) << 30)) begin
          t_nxt = c_r;
          u_nxt = u_r + (SW'(p_r) << b_r);
          m_nxt[b_r] = 1'b1;
        end
        if (b_r == 4'd0) begin
          state_nxt = S_FIN;
        end else begin
          b_nxt = b_r - 4'd1;
          state_nxt = S_S0;
        end
      end
      S_FIN: begin
        if (dneg_r) score_nxt = $signed(16'(-m_r));
        else if (m_r[15]) score_nxt = 16'sd32767;
        else score_nxt = $signed(m_r);
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    last_r <= last_nxt;
    prod_r <= prod_nxt;
    sh_r <= sh_nxt;
    pneg_r <= pneg_nxt;
    dot_r <= dot_nxt;
    na_r <= na_nxt;
    nb_r <= nb_nxt;
    ad_r <= ad_nxt;
    dneg_r <= dneg_nxt;
    p_r <= p_nxt;
    d_r <= d_nxt;
    lm_r <= lm_nxt;
    t_r <= t_nxt;
    u_r <= u_nxt;
    c_r <= c_nxt;
    m_r <= m_nxt;
    b_r <= b_nxt;
    score_r <= score_nxt;
  end

  assign sts.ready = (state_r == S_IDLE);
  assign sts.done  = (state_r == S_DONE);
  assign sts.score = score_r;

endmodule

`default_nettype wire

### rtl/cosine_similarity_top_k_search.sv
// Top level: document store, query scan over valid slots and ranked result list.
//
//  channel | ports                                   | transaction
//  in      | in_valid/in_ready, mode..top_count      | one element, or a remove
//  out     | out_valid/out_ready, result_slot..last  | one result
//  cfg     | cfg_write_enable, cfg_write_data        | vector_dimension write
//
// After reset the slot-valid memory is cleared slot by slot, with in_ready low.
// A document element or a mode-3 transfer is taken while idle. A document end that stores
// copies the staged vector into its slot. A remove waits on out_ready. A query end scans
// every slot and runs each valid one through the shared multiplier and root search, then
// emits the results. in_ready is low during a run; the output register holds under stall.
`timescale 1ns / 1ps
`default_nettype none

module cosine_similarity_top_k_search
  import cstk_pkg::*;
#(
  parameter int MAX_DOCS = 1024,
  parameter int MAX_DIM  = 64,
  parameter int MAX_TOPK = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic [9:0]         in_slot,
  input  wire logic signed [15:0] in_element_value,
  input  wire logic               in_last_element,
  input  wire logic [5:0]         in_top_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [9:0]              out_result_slot,
  output logic signed [15:0]      out_score,
  output logic                    out_found,
  output logic                    out_last_result,
  input  wire logic               cfg_write_enable,
  input  wire logic [6:0]         cfg_write_data
);

  localparam int SLOT_W = $clog2(MAX_DOCS);
  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 2);
  localparam int EW     = (CNT_W > 7) ? CNT_W : 7;
  localparam int KW     = $clog2(MAX_TOPK + 1);
  localparam int TK_W   = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
  localparam int VA_W   = SLOT_W + DIM_W;
  localparam int VDEPTH = MAX_DOCS * (2 ** DIM_W);
  localparam int NORM_W = 33 + $clog2(MAX_DIM);

  top_state_t state_r, state_nxt;
  logic [6:0] dim_r;
  logic [CNT_W-1:0] st_cnt_r, st_cnt_nxt, q_cnt_r, q_cnt_nxt, cp_r, cp_nxt;
  logic [SLOT_W-1:0] cp_slot_r, cp_slot_nxt, scan_r, scan_nxt, clr_r, clr_nxt;
  logic [DIM_W-1:0] idx_r, idx_nxt;
  logic [9:0] rm_slot_r, rm_slot_nxt;
  logic rm_ok_r, rm_ok_nxt;
  logic [KW-1:0] k_r, k_nxt, n_r, n_nxt;
  logic [SLOT_W-1:0] bsl_r [MAX_TOPK];
  logic [SLOT_W-1:0] bsl_nxt [MAX_TOPK];
  logic signed [15:0] bsc_r [MAX_TOPK];
  logic signed [15:0] bsc_nxt [MAX_TOPK];
  logic out_valid_r, out_valid_nxt, out_found_r, out_found_nxt, out_last_r, out_last_nxt;
  logic [9:0] out_slot_r, out_slot_nxt;
  logic signed [15:0] out_score_r, out_score_nxt;

  // memories
  logic [15:0] vmem [VDEPTH];
  logic [15:0] smem [MAX_DIM];
  logic [15:0] qmem [MAX_DIM];
  logic        valid_mem [MAX_DOCS];
  logic [15:0] v_rd_r, s_rd_r, q_rd_r;
  logic        val_rd_r;
  logic        s_we, q_we, v_we, val_we, val_wd, val_re;
  logic [DIM_W-1:0] s_wa, q_wa;
  logic [SLOT_W-1:0] val_wa, val_ra;

  logic accept, out_free, dim_ok, slot_ok, adv, ins;
  logic [SLOT_W-1:0] in_idx;
  logic [CNT_W-1:0] st_inc, q_inc;
  logic [EW-1:0] dim_e;
  logic [MAX_TOPK-1:0] ge;
  logic [TK_W-1:0] kidx;
  score_ctl_t su_ctl;
  score_sts_t su_sts;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign dim_e    = EW'(dim_r);
  assign dim_ok   = (dim_r != 7'd0) && (dim_e <= EW'(MAX_DIM));
  assign slot_ok  = 32'(in_slot) < 32'(MAX_DOCS);
  assign in_idx   = SLOT_W'(in_slot);
  assign st_inc   = (EW'(st_cnt_r) <= EW'(MAX_DIM)) ? st_cnt_r + 1'b1 : st_cnt_r;
  assign q_inc    = (EW'(q_cnt_r) <= EW'(MAX_DIM)) ? q_cnt_r + 1'b1 : q_cnt_r;
  assign kidx     = TK_W'(k_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 7'd64;
    end else if (cfg_write_enable) begin
      dim_r <= cfg_write_data;
    end
  end

  // rank position: entries already holding a score >= the new one stay ahead
  always_comb begin
    for (int j = 0; j < MAX_TOPK; j++) begin
      ge[j] = (KW'(j) < n_r) && (bsc_r[j] >= su_sts.score);
    end
    ins = !ge[kidx];
  end

  always_comb begin
    state_nxt = state_r;
    st_cnt_nxt = st_cnt_r;
    q_cnt_nxt = q_cnt_r;
    cp_nxt = cp_r;
    cp_slot_nxt = cp_slot_r;
    scan_nxt = scan_r;
    clr_nxt = clr_r;
    idx_nxt = idx_r;
    rm_slot_nxt = rm_slot_r;
    rm_ok_nxt = rm_ok_r;
    k_nxt = k_r;
    n_nxt = n_r;
    bsl_nxt = bsl_r;
    bsc_nxt = bsc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_slot_nxt = out_slot_r;
    out_score_nxt = out_score_r;
    out_found_nxt = out_found_r;
    out_last_nxt = out_last_r;
    s_we = 1'b0;
    q_we = 1'b0;
    v_we = 1'b0;
    val_we = 1'b0;
    val_wd = 1'b0;
    val_wa = in_idx;
    val_re = 1'b0;
    val_ra = scan_r;
    s_wa = DIM_W'(st_cnt_r);
    q_wa = DIM_W'(q_cnt_r);
    su_ctl = '0;
    adv = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        val_we = 1'b1;
        val_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == 32'(MAX_DOCS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        val_re = 1'b1;
        val_ra = in_idx;
        if (accept) begin
          case (in_mode)
            MODE_DOC: begin
              s_we = EW'(st_cnt_r) < EW'(MAX_DIM);
              st_cnt_nxt = st_inc;
              if (in_last_element) begin
                st_cnt_nxt = '0;
                if (slot_ok && dim_ok && EW'(st_inc) == dim_e) begin
                  cp_slot_nxt = in_idx;
                  cp_nxt = '0;
                  state_nxt = ST_COPY;
                end
              end
            end
            MODE_REMOVE: begin
              rm_slot_nxt = in_slot;
              rm_ok_nxt = slot_ok;
              val_we = slot_ok;
              state_nxt = ST_REMOVE;
            end
            MODE_QUERY: begin
              q_we = EW'(q_cnt_r) < EW'(MAX_DIM);
              q_cnt_nxt = q_inc;
              if (in_last_element) begin
                q_cnt_nxt = '0;
                if (in_top_count == 6'd0 || 32'(in_top_count) > 32'(MAX_TOPK)) begin
                  k_nxt = KW'(MAX_TOPK);
                end else begin
                  k_nxt = KW'(in_top_count);
                end
                n_nxt = '0;
                if (dim_ok && EW'(q_inc) == dim_e) begin
                  scan_nxt = '0;
                  state_nxt = ST_SC_RD;
                end else begin
                  state_nxt = ST_NOTFOUND;
                end
              end
            end
            default: ;
          endcase
        end
      end
      // staging read is registered; the slot write trails it by one address
      ST_COPY: begin
        v_we = (cp_r != '0);
        cp_nxt = cp_r + 1'b1;
        if (EW'(cp_r) == dim_e) begin
          val_we = 1'b1;
          val_wa = cp_slot_r;
          val_wd = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REMOVE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt = rm_slot_r;
          out_score_nxt = 16'sd0;
          out_found_nxt = val_rd_r && rm_ok_r;
          out_last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_NOTFOUND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt = 10'd0;
          out_score_nxt = 16'sd0;
          out_found_nxt = 1'b0;
          out_last_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SC_RD: begin
        val_re = 1'b1;
        state_nxt = ST_SC_CHK;
      end
      ST_SC_CHK: begin
        if (val_rd_r) begin
          idx_nxt = '0;
          state_nxt = ST_EL_RD;
        end else begin
          adv = 1'b1;
        end
      end
      ST_EL_RD: state_nxt = ST_EL_GO;
      ST_EL_GO: begin
        if (su_sts.ready) begin
          su_ctl.el_valid = 1'b1;
          su_ctl.el_first = (idx_r == '0);
          su_ctl.el_last = (EW'(idx_r) == dim_e - 1'b1);
          if (su_ctl.el_last) begin
            state_nxt = ST_EL_WAIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = ST_EL_RD;
          end
        end
      end
      ST_EL_WAIT: begin
        if (su_sts.done) begin
          if (ins) begin
            for (int j = 0; j < MAX_TOPK; j++) begin
              if (!ge[j]) begin
                if (j == 0 || ge[(j == 0) ? 0 : j - 1]) begin
                  bsl_nxt[j] = scan_r;
                  bsc_nxt[j] = su_sts.score;
                end else begin
                  bsl_nxt[j] = bsl_r[(j == 0) ? 0 : j - 1];
                  bsc_nxt[j] = bsc_r[(j == 0) ? 0 : j - 1];
                end
              end
            end
            if (n_r < k_r) n_nxt = n_r + 1'b1;
          end
          adv = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt = 10'(bsl_r[0]);
          out_score_nxt = bsc_r[0];
          out_found_nxt = 1'b1;
          out_last_nxt = (n_r == KW'(1));
          for (int j = 0; j < MAX_TOPK - 1; j++) begin
            bsl_nxt[j] = bsl_r[j + 1];
            bsc_nxt[j] = bsc_r[j + 1];
          end
          n_nxt = n_r - 1'b1;
          if (n_r == KW'(1)) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // move to the next slot, or finish the scan
    if (adv) begin
      if (32'(scan_r) == 32'(MAX_DOCS - 1)) begin
        state_nxt = (n_nxt == '0) ? ST_NOTFOUND : ST_EMIT;
      end else begin
        scan_nxt = scan_r + 1'b1;
        state_nxt = ST_SC_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      st_cnt_r <= '0;
      q_cnt_r <= '0;
      n_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      st_cnt_r <= st_cnt_nxt;
      q_cnt_r <= q_cnt_nxt;
      n_r <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r <= cp_nxt;
    cp_slot_r <= cp_slot_nxt;
    scan_r <= scan_nxt;
    idx_r <= idx_nxt;
    rm_slot_r <= rm_slot_nxt;
    rm_ok_r <= rm_ok_nxt;
    k_r <= k_nxt;
    bsl_r <= bsl_nxt;
    bsc_r <= bsc_nxt;
    out_slot_r <= out_slot_nxt;
    out_score_r <= out_score_nxt;
    out_found_r <= out_found_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= in_element_value;
    s_rd_r <= smem[DIM_W'(cp_r)];
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_wa] <= in_element_value;
    q_rd_r <= qmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (v_we) vmem[VA_W'({cp_slot_r, DIM_W'(cp_r - 1'b1)})] <= s_rd_r;
    v_rd_r <= vmem[VA_W'({scan_r, idx_r})];
  end

  always_ff @(posedge clk) begin
    if (val_re) val_rd_r <= valid_mem[val_ra];
    if (val_we) valid_mem[val_wa] <= val_wd;
  end

  cstk_score #(
    .NORM_W(NORM_W)
  ) u_score (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (su_ctl),
    .x    ($signed(q_rd_r)),
    .y    ($signed(v_rd_r)),
    .sts  (su_sts)
  );

  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_score       = out_score_r;
  assign out_found       = out_found_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

### rtl/cstk_checker.sv
// Port-level checks for the search block, bound onto the top level.
`timescale 1ns / 1ps
`default_nettype none

module cstk_port_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [9:0]         out_result_slot,
  input wire logic signed [15:0] out_score,
  input wire logic               out_found,
  input wire logic               out_last_result
);

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("outputs active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_slot) && $stable(out_score)
      && $stable(out_found) && $stable(out_last_result))
    else $error("stalled result changed");

  // a run with more results pending keeps the input closed
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> !in_ready)
    else $error("input opened mid-run");

  a_empty_answer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_score == 16'sd0 && out_last_result)
    else $error("empty answer malformed");

endmodule

bind cosine_similarity_top_k_search cstk_port_checker u_cstk_checker (.*);

`default_nettype wire
